### src/assert_macros.svh
// assertion macros used by the parser rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational check sampled on every rising clock edge outside reset
`define SVCB_ASSERT(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("svcb assertion failed");

// implication checked in the cycle after the condition
`define SVCB_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("svcb assertion failed");

`endif

### src/svcb_pve_pkg.sv
// shared types and constants of the svcb parameter value extractor
package svcb_pve_pkg;

   typedef struct packed {
      logic [7:0]  record_byte;
      logic [15:0] record_length;
   } req_type;

   typedef struct packed {
      logic [7:0] value_byte;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   localparam logic [1:0] STATUS_VALUE = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_NONE  = 2'd2;

   localparam logic [7:0]  LABEL_FLAG_MASK  = 8'hc0;
   localparam logic [15:0] WANTED_KEY_RESET = 16'd5;

endpackage

### src/svcb_param_value_extractor_unit.sv
// top level of the svcb parameter value extractor
// usage:
//   req_* carries one record-data byte per request with the record's total
//   length; a request is taken at a clock edge with req_valid high and
//   req_stall low.
//   rsp_* gives at most one result per request: a value byte (status 0),
//   found-empty (status 1) or none (status 2), with last on the terminal
//   result of each record; a result is taken when rsp_valid is high and
//   rsp_stall is low.
//   csr_write_enable/csr_write_data set the wanted parameter key (reset 5);
//   write it only while the block is idle.
// timing: one request per cycle sustained while rsp_stall is low; a request
//   is parsed out of the input register at the first edge at which the
//   result register can load, and its result is registered at that same
//   edge, where rsp_valid then rises. the parse logic between input and
//   result registers is combinational.
// stall: when rsp_stall holds a waiting result, the input register still
//   fills once, then req_stall rises until the result is taken.
// reset: synchronous, both registers empty, parser at the start of a record.
module svcb_param_value_extractor_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  svcb_pve_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output svcb_pve_pkg::rsp_type rsp_data,
   input  logic                  csr_write_enable,
   input  logic [15:0]           csr_write_data
);
   import svcb_pve_pkg::*;

   logic [15:0] key_ff, key_in;
   logic        advance;
   logic        item_valid;
   req_type     item;
   logic        res_valid;
   rsp_type     res;

   assign key_in = csr_write_enable ? csr_write_data : key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= WANTED_KEY_RESET;
      end else begin
         key_ff <= key_in;
      end
   end

   svcb_pve_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   svcb_pve_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .fire       (item_valid && advance),
      .item       (item),
      .wanted_key (key_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   svcb_pve_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load_valid (res_valid),
      .load_data  (res),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

### src/svcb_pve_in_stage.sv
// input register of the extractor, loads a request whenever it is not stalled
module svcb_pve_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  svcb_pve_pkg::req_type req_data,
   input  logic                 advance,
   output logic                 item_valid,
   output svcb_pve_pkg::req_type item
);
   import svcb_pve_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;

   assign req_stall = valid_ff && !advance;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign item_valid = valid_ff;
   assign item       = data_ff;

endmodule

### src/svcb_pve_parser.sv
// record walker: per-byte state update and result decision
module svcb_pve_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  svcb_pve_pkg::req_type item,
   input  logic [15:0]          wanted_key,
   output logic                 res_valid,
   output svcb_pve_pkg::rsp_type res
);
   import svcb_pve_pkg::*;
   `include "assert_macros.svh"

   localparam logic [2:0] PH_PRIO     = 3'd0;
   localparam logic [2:0] PH_NAME_LEN = 3'd1;
   localparam logic [2:0] PH_LABEL    = 3'd2;
   localparam logic [2:0] PH_KEY_HI   = 3'd3;
   localparam logic [2:0] PH_KEY_LO   = 3'd4;
   localparam logic [2:0] PH_LEN_HI   = 3'd5;
   localparam logic [2:0] PH_LEN_LO   = 3'd6;
   localparam logic [2:0] PH_VALUE    = 3'd7;

   logic [15:0] pos_ff, pos_in;
   logic [2:0]  phase_ff, phase_in;
   logic [5:0]  label_ff, label_in;
   logic [7:0]  hold_ff, hold_in;
   logic [15:0] key_ff, key_in;
   logic [15:0] value_ff, value_in;
   logic        decided_ff, decided_in;

   logic [7:0]  b;
   logic [16:0] pos_next17;
   logic [16:0] len17;
   logic [15:0] vlen;
   logic [5:0]  label_dec;
   logic [15:0] value_dec;
   logic        key_match;
   logic        record_end;
   logic        label_overrun;
   logic        value_overrun;
   logic        give_none;

   assign b             = item.record_byte;
   assign len17         = {1'b0, item.record_length};
   assign pos_next17    = {1'b0, pos_ff} + 17'd1;
   assign vlen          = {hold_ff, b};
   assign label_dec     = (label_ff != 6'd0) ? label_ff - 6'd1 : label_ff;
   assign value_dec     = (value_ff != 16'd0) ? value_ff - 16'd1 : value_ff;
   assign key_match     = (key_ff == wanted_key);
   assign record_end    = (pos_next17 >= len17);
   assign label_overrun = ((pos_next17 + {9'd0, b}) > len17);
   assign value_overrun = ((pos_next17 + {1'b0, vlen}) > len17);

   always_comb begin
      pos_in     = pos_ff;
      phase_in   = phase_ff;
      label_in   = label_ff;
      hold_in    = hold_ff;
      key_in     = key_ff;
      value_in   = value_ff;
      decided_in = decided_ff;
      give_none  = 1'b0;
      res_valid  = 1'b0;
      res        = '{value_byte: 8'd0, status: STATUS_VALUE, last: 1'b0};
      if (fire) begin
         if (!decided_ff) begin
            case (phase_ff)
               PH_PRIO: begin
                  if (pos_ff == 16'd0) begin
                     hold_in = b;
                  end else if (vlen == 16'd0) begin
                     // priority zero is alias mode
                     give_none = 1'b1;
                  end else begin
                     phase_in = PH_NAME_LEN;
                  end
               end
               PH_NAME_LEN: begin
                  if (b == 8'd0) begin
                     phase_in = PH_KEY_HI;
                  end else if ((b & LABEL_FLAG_MASK) != 8'd0) begin
                     give_none = 1'b1;
                  end else if (label_overrun) begin
                     give_none = 1'b1;
                  end else begin
                     label_in = b[5:0];
                     phase_in = PH_LABEL;
                  end
               end
               PH_LABEL: begin
                  label_in = label_dec;
                  if (label_dec == 6'd0) begin
                     phase_in = PH_NAME_LEN;
                  end
               end
               PH_KEY_HI: begin
                  hold_in  = b;
                  phase_in = PH_KEY_LO;
               end
               PH_KEY_LO: begin
                  key_in   = vlen;
                  phase_in = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  hold_in  = b;
                  phase_in = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  if (value_overrun) begin
                     give_none = 1'b1;
                  end else if (vlen == 16'd0) begin
                     if (key_match) begin
                        res_valid  = 1'b1;
                        res        = '{value_byte: 8'd0, status: STATUS_EMPTY, last: 1'b1};
                        decided_in = 1'b1;
                     end else begin
                        phase_in = PH_KEY_HI;
                     end
                  end else begin
                     // hold now carries the match flag for the value walk
                     value_in = vlen;
                     hold_in  = key_match ? 8'd1 : 8'd0;
                     phase_in = PH_VALUE;
                  end
               end
               default: begin
                  value_in = value_dec;
                  if (hold_ff != 8'd0) begin
                     res_valid = 1'b1;
                     res       = '{value_byte: b, status: STATUS_VALUE,
                                   last: (value_dec == 16'd0)};
                     if (value_dec == 16'd0) begin
                        decided_in = 1'b1;
                     end
                  end else if (value_dec == 16'd0) begin
                     phase_in = PH_KEY_HI;
                  end
               end
            endcase
         end
         if (give_none) begin
            res_valid  = 1'b1;
            res        = '{value_byte: 8'd0, status: STATUS_NONE, last: 1'b1};
            decided_in = 1'b1;
         end
         if (record_end) begin
            // undecided record closes with none, also replacing a non-final value byte
            if (!decided_in) begin
               res_valid = 1'b1;
               res       = '{value_byte: 8'd0, status: STATUS_NONE, last: 1'b1};
            end
            pos_in     = 16'd0;
            phase_in   = PH_PRIO;
            label_in   = 6'd0;
            hold_in    = 8'd0;
            key_in     = 16'd0;
            value_in   = 16'd0;
            decided_in = 1'b0;
         end else begin
            pos_in = pos_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 16'd0;
         phase_ff   <= PH_PRIO;
         label_ff   <= 6'd0;
         hold_ff    <= 8'd0;
         key_ff     <= 16'd0;
         value_ff   <= 16'd0;
         decided_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         phase_ff   <= phase_in;
         label_ff   <= label_in;
         hold_ff    <= hold_in;
         key_ff     <= key_in;
         value_ff   <= value_in;
         decided_ff <= decided_in;
      end
   end

   `SVCB_ASSERT(a_terminal_has_last, clock, reset,
      !(res_valid && res.status != STATUS_VALUE) || res.last)
   `SVCB_ASSERT(a_no_result_after_decision, clock, reset,
      !(fire && decided_ff) || !res_valid || res.status == STATUS_NONE)
   `SVCB_ASSERT(a_decided_is_silent, clock, reset,
      !(fire && decided_ff) || !res_valid || !record_end)
   `SVCB_ASSERT_NEXT(a_record_end_clears, clock, reset, fire && record_end,
      pos_ff == 16'd0 && phase_ff == PH_PRIO && !decided_ff)
   `SVCB_ASSERT(a_status_in_range, clock, reset,
      !res_valid || res.status == STATUS_VALUE || res.status == STATUS_EMPTY || res.status == STATUS_NONE)

endmodule

### src/svcb_pve_out_stage.sv
// result register, loads whenever empty or being taken
module svcb_pve_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   input  svcb_pve_pkg::rsp_type load_data,
   output logic                 advance,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output svcb_pve_pkg::rsp_type rsp_data
);
   import svcb_pve_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign advance = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (advance) begin
         valid_in = load_valid;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
